FILE: design/lkv_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Used by lkv_store, lru_key_value_cache, lru_lookup_checker and testbench; depends on nothing else.
package lkv_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W   = IDX_W;
	localparam int CAP_W    = 5;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(CAPACITY);

	// operation codes of an input item
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	// register index, taken from the word address
	localparam logic REG_ACTIVE_CAPACITY = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_EVICT,
		S_INSERT
	} state_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_PROMOTE,
		OP_EVICT,
		OP_INSERT
	} store_op_t;

	typedef struct packed {
		store_op_t              op;
		logic [IDX_W-1:0]       idx;
		logic [CAP_W-1:0]       limit;
		logic                   wr_value;
	} store_cmd_t;

endpackage

FILE: design/lkv_store.sv
// Entry storage for the LRU key/value cache: valid bits, recency ranks, keys, values.
// Applies one promote, evict or insert operation per cycle; depends on lkv_pkg.
module lkv_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkv_pkg::store_cmd_t           scmd,
	input  logic [lkv_pkg::KEY_W-1:0]     wr_key,
	input  logic [lkv_pkg::VAL_W-1:0]     wr_value,
	input  logic [lkv_pkg::IDX_W-1:0]     rd_idx,
	output logic                          rd_valid,
	output logic [lkv_pkg::KEY_W-1:0]     rd_key,
	output logic [lkv_pkg::VAL_W-1:0]     rd_value
);

	logic [lkv_pkg::CAPACITY-1:0]                     valid_q;
	logic [lkv_pkg::CAPACITY-1:0][lkv_pkg::RANK_W-1:0] rank_q;
	logic [lkv_pkg::KEY_W-1:0]                        key_q   [lkv_pkg::CAPACITY];
	logic [lkv_pkg::VAL_W-1:0]                        value_q [lkv_pkg::CAPACITY];

	logic [lkv_pkg::RANK_W-1:0] promote_rank;
	logic [lkv_pkg::IDX_W-1:0]  free_idx;

	assign rd_valid     = valid_q[rd_idx];
	assign rd_key       = key_q[rd_idx];
	assign rd_value     = value_q[rd_idx];
	assign promote_rank = rank_q[scmd.idx];

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = lkv_pkg::CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = lkv_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rank_q  <= '0;
		end else begin
			case (scmd.op)
				lkv_pkg::OP_PROMOTE: begin
					// younger entries age by one, the touched entry becomes newest
					for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
						if (valid_q[i] && rank_q[i] < promote_rank) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					rank_q[scmd.idx] <= '0;
				end
				lkv_pkg::OP_EVICT: begin
					// drop every entry at or beyond the last allowed rank
					for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
						if (valid_q[i] &&
						    lkv_pkg::CAP_W'(rank_q[i]) >= scmd.limit) begin
							valid_q[i] <= 1'b0;
							rank_q[i]  <= '0;
						end
					end
				end
				lkv_pkg::OP_INSERT: begin
					for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
						if (valid_q[i]) begin
							rank_q[i] <= rank_q[i] + 1'b1;
						end
					end
					valid_q[free_idx] <= 1'b1;
					rank_q[free_idx]  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scmd.op == lkv_pkg::OP_INSERT) begin
			key_q[free_idx]   <= wr_key;
			value_q[free_idx] <= wr_value;
		end else if (scmd.op == lkv_pkg::OP_PROMOTE && scmd.wr_value) begin
			value_q[scmd.idx] <= wr_value;
		end
	end

endmodule

FILE: design/lru_key_value_cache.sv
// LRU key/value cache: one key comparator scans the entries, one slot per cycle.
// Only one command is in flight: start is taken only while busy is low, and busy stays
// high through the scan, the promote of a hit and the evict and insert of a new put.
// The scan length over the 16 slots sets the rate. Results are strobed by done for one
// cycle and cannot be stalled. Reset clears all entries and sets active_capacity to 16.
module lru_key_value_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [lkv_pkg::KEY_W-1:0]     lookup_key,
	input  logic [lkv_pkg::VAL_W-1:0]     data_in,
	output logic                          done,
	output logic                          found,
	output logic [lkv_pkg::VAL_W-1:0]     data_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	lkv_pkg::state_t            state_q, state_d;
	logic [lkv_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic                       cmd_q;
	logic [lkv_pkg::KEY_W-1:0]  key_q;
	logic [lkv_pkg::VAL_W-1:0]  data_q;
	logic [lkv_pkg::CAP_W-1:0]  cap_q;
	logic                       done_q, done_d;
	logic                       found_q, found_d;
	logic [lkv_pkg::VAL_W-1:0]  dout_q, dout_d;

	lkv_pkg::store_cmd_t        scmd;
	logic                       rd_valid;
	logic [lkv_pkg::KEY_W-1:0]  rd_key;
	logic [lkv_pkg::VAL_W-1:0]  rd_value;
	logic                       match;
	logic [lkv_pkg::CAP_W-1:0]  eff_cap;
	logic                       accept;

	assign busy    = (state_q != lkv_pkg::S_IDLE);
	assign accept  = start && !busy;
	assign match   = rd_valid && (rd_key == key_q);
	assign pready  = 1'b1;
	assign done    = done_q;
	assign found   = found_q;
	assign data_out = dout_q;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = lkv_pkg::CAP_W'(1);
		end else if (cap_q > lkv_pkg::CAP_W'(lkv_pkg::CAPACITY)) begin
			eff_cap = lkv_pkg::CAP_W'(lkv_pkg::CAPACITY);
		end else begin
			eff_cap = cap_q;
		end
	end

	always_comb begin
		if (paddr[2] == lkv_pkg::REG_ACTIVE_CAPACITY) begin
			prdata = {{(32 - lkv_pkg::CAP_W){1'b0}}, cap_q};
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == lkv_pkg::REG_ACTIVE_CAPACITY) begin
			cap_q <= pwdata[lkv_pkg::CAP_W-1:0];
		end
	end

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		done_d        = 1'b0;
		found_d       = found_q;
		dout_d        = dout_q;
		scmd.op       = lkv_pkg::OP_NOP;
		scmd.idx      = idx_q;
		scmd.limit    = eff_cap - 1'b1;
		scmd.wr_value = 1'b0;
		case (state_q)
			lkv_pkg::S_IDLE: begin
				if (accept) begin
					idx_d   = '0;
					state_d = lkv_pkg::S_SCAN;
				end
			end
			lkv_pkg::S_SCAN: begin
				if (match) begin
					state_d = lkv_pkg::S_UPDATE;
				end else if (idx_q == lkv_pkg::IDX_W'(lkv_pkg::CAPACITY - 1)) begin
					if (cmd_q == lkv_pkg::CMD_GET) begin
						done_d  = 1'b1;
						found_d = 1'b0;
						dout_d  = lkv_pkg::MISS_VALUE;
						state_d = lkv_pkg::S_IDLE;
					end else begin
						state_d = lkv_pkg::S_EVICT;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			lkv_pkg::S_UPDATE: begin
				// hold idx on the hit slot; read the value before a put overwrites it
				scmd.op       = lkv_pkg::OP_PROMOTE;
				scmd.wr_value = (cmd_q == lkv_pkg::CMD_PUT);
				if (cmd_q == lkv_pkg::CMD_GET) begin
					done_d  = 1'b1;
					found_d = 1'b1;
					dout_d  = rd_value;
				end
				state_d = lkv_pkg::S_IDLE;
			end
			lkv_pkg::S_EVICT: begin
				scmd.op = lkv_pkg::OP_EVICT;
				state_d = lkv_pkg::S_INSERT;
			end
			lkv_pkg::S_INSERT: begin
				scmd.op = lkv_pkg::OP_INSERT;
				state_d = lkv_pkg::S_IDLE;
			end
			default: begin
				state_d = lkv_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		found_q <= found_d;
		dout_q  <= dout_d;
		if (accept) begin
			cmd_q  <= cmd;
			key_q  <= lookup_key;
			data_q <= data_in;
		end
	end

	lkv_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.scmd     (scmd),
		.wr_key   (key_q),
		.wr_value (data_q),
		.rd_idx   (idx_q),
		.rd_valid (rd_valid),
		.rd_key   (rd_key),
		.rd_value (rd_value)
	);

endmodule

FILE: sim/lru_lookup_checker.sv
`timescale 1ns / 1ps
// Scoreboard for lru_key_value_cache: keeps a shadow copy of the store and its capacity
// register, predicts the answer of every get, and compares it with the done strobe.
// Depends on lkv_pkg only.
module lru_lookup_checker
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             cmd,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] data_in,
	input  logic             done,
	input  logic             found,
	input  logic [VAL_W-1:0] data_out,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	output int               fail_count,
	output int               answers_due
);

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} answer_t;

	answer_t          answer_queue [$];
	logic             shadow_valid [CAPACITY];
	logic [KEY_W-1:0] shadow_key   [CAPACITY];
	logic [VAL_W-1:0] shadow_value [CAPACITY];
	logic [RANK_W-1:0] shadow_age  [CAPACITY];
	logic [CAP_W-1:0] capacity_reg;

	function automatic int usable_slots();
		if (capacity_reg == '0) return 1;
		if (capacity_reg > CAPACITY) return CAPACITY;
		return int'(capacity_reg);
	endfunction

	function automatic int slot_holding(logic [KEY_W-1:0] key);
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i] && shadow_key[i] == key) return i;
		return -1;
	endfunction

	// age every entry younger than slot s, then make s the newest
	function automatic void make_newest(int s);
		logic [RANK_W-1:0] r;
		r = shadow_age[s];
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i] && shadow_age[i] < r) shadow_age[i]++;
		shadow_age[s] = '0;
	endfunction

	function automatic void store_new_key(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		int oldest_kept;
		int free_slot;
		oldest_kept = usable_slots() - 1;
		free_slot = -1;
		// drop the least recent entry, or everything past a lowered capacity
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i] && int'(shadow_age[i]) >= oldest_kept) begin
				shadow_valid[i] = 1'b0;
				shadow_age[i] = '0;
			end
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i]) shadow_age[i]++;
			else if (free_slot < 0) free_slot = i;
		if (free_slot >= 0) begin
			shadow_valid[free_slot] = 1'b1;
			shadow_key[free_slot] = key;
			shadow_value[free_slot] = value;
			shadow_age[free_slot] = '0;
		end
	endfunction

	function automatic void apply_command(logic op, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] value);
		int s;
		answer_t a;
		s = slot_holding(key);
		if (op == CMD_GET) begin
			if (s >= 0) begin
				make_newest(s);
				a.hit = 1'b1;
				a.value = shadow_value[s];
			end else begin
				a.hit = 1'b0;
				a.value = MISS_VALUE;
			end
			answer_queue.push_back(a);
		end else if (s >= 0) begin
			shadow_value[s] = value;
			make_newest(s);
		end else begin
			store_new_key(key, value);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t head;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_key[i] = '0;
				shadow_value[i] = '0;
				shadow_age[i] = '0;
			end
			capacity_reg = CAP_RESET;
			answer_queue.delete();
			fail_count = 0;
			answers_due = 0;
		end else begin
			// the answer of an older get leaves before a new transfer is applied
			if (done) begin
				if (answer_queue.size() == 0) begin
					fail_count++;
					$display("%0t: answer with no get pending: found=%0b data_out=%h",
						$time, found, data_out);
				end else begin
					head = answer_queue.pop_front();
					if (found !== head.hit) begin
						fail_count++;
						$display("%0t: found expected %0b actual %0b", $time, head.hit, found);
					end
					if (data_out !== head.value) begin
						fail_count++;
						$display("%0t: data_out expected %h actual %h",
							$time, head.value, data_out);
					end
				end
			end
			if (start && !busy) apply_command(cmd, lookup_key, data_in);
			if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_CAPACITY)
				capacity_reg = pwdata[CAP_W-1:0];
			answers_due = answer_queue.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the lru_key_value_cache test: clock, reset, get/put traffic, capacity writes
// and the verdict. Depends on lkv_pkg, lru_key_value_cache and lru_lookup_checker.
module testbench;
	import lkv_pkg::*;

	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 180;
	localparam int PHASE_COUNT    = 10;
	localparam int POOL_DEPTH     = 24;
	localparam logic [2:0] ADDR_CAPACITY = {REG_ACTIVE_CAPACITY, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED = {~REG_ACTIVE_CAPACITY, 2'b00};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             cmd;
	logic [KEY_W-1:0] lookup_key;
	logic [VAL_W-1:0] data_in;
	logic             done;
	logic             found;
	logic [VAL_W-1:0] data_out;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [2:0]       paddr;
	logic [31:0]      pwdata;
	logic [31:0]      prdata;
	logic             pready;
	int               fail_count;
	int               answers_due;
	int               stall_cycles;

	lru_key_value_cache dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.lookup_key(lookup_key), .data_in(data_in), .done(done), .found(found),
		.data_out(data_out), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lru_lookup_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.lookup_key(lookup_key), .data_in(data_in), .done(done), .found(found),
		.data_out(data_out), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .answers_due(answers_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial stall_cycles = 0;

	// end the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic issue(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		lookup_key <= key;
		data_in <= value;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(int cycles);
		for (int i = 0; i < cycles; i++) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// hold the sender until every get has been answered
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (answers_due != 0) @(negedge clk);
	endtask

	// a put never answers, so let the block finish it before touching the register
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_phase(logic [CAP_W-1:0] cap, bit calm);
		logic [KEY_W-1:0] pool [POOL_DEPTH];
		logic [31:0]      word;
		logic [KEY_W-1:0] key;
		logic             op;
		int               span;
		word = $urandom();
		word[CAP_W-1:0] = cap;
		write_reg(ADDR_CAPACITY, word);
		span = (cap == '0) ? 1 : ((cap > CAPACITY) ? CAPACITY : int'(cap));
		span += 3;
		for (int i = 0; i < POOL_DEPTH; i++) pool[i] = $urandom();
		case ($urandom_range(0, 3))
			0: pool[0] = 32'h8000_0000;
			1: pool[0] = 32'h7FFF_FFFF;
			2: pool[0] = '0;
			default: pool[0] = '1;
		endcase
		// mostly keys from a pool a little larger than the capacity, so hits,
		// updates and evictions all keep happening
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			op = ($urandom_range(0, 99) < 50) ? CMD_GET : CMD_PUT;
			key = ($urandom_range(0, 99) < 88) ? pool[$urandom_range(0, span - 1)] : $urandom();
			issue(op, key, $urandom());
			if (!calm) begin
				if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 17));
				else if ($urandom_range(0, 149) == 0) drain();
			end
		end
	endtask

	initial begin : stimulus
		logic [CAP_W-1:0] schedule [PHASE_COUNT];
		schedule = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd9, 5'd31, 5'd2, 5'd16, 5'd12, 5'd17};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_GET;
		lookup_key = '0;
		data_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty store, extreme keys and values, hits, a miss, an update
		issue(CMD_GET, 32'h0000_0000, $urandom());
		issue(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(CMD_GET, 32'h8000_0000, $urandom());
		issue(CMD_GET, 32'h7FFF_FFFF, $urandom());
		issue(CMD_GET, 32'hFFFF_FFFF, $urandom());
		issue(CMD_GET, 32'h0000_0000, $urandom());
		issue(CMD_GET, 32'h0000_0001, $urandom());
		issue(CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
		issue(CMD_GET, 32'h0000_0000, $urandom());

		// a write to an unmapped register must leave the capacity alone
		write_reg(ADDR_UNMAPPED, 32'h0000_0001);
		issue(CMD_PUT, 32'h1111_1111, 32'h0000_0001);
		issue(CMD_GET, 32'h8000_0000, $urandom());

		// shrink a partly filled store to two entries
		write_reg(ADDR_CAPACITY, 32'h0000_0002);
		issue(CMD_PUT, 32'h2222_2222, 32'h0000_0002);
		issue(CMD_GET, 32'h7FFF_FFFF, $urandom());
		issue(CMD_GET, 32'h8000_0000, $urandom());
		issue(CMD_GET, 32'h2222_2222, $urandom());

		// zero capacity behaves as one entry
		write_reg(ADDR_CAPACITY, 32'h0000_0000);
		issue(CMD_PUT, 32'h3333_3333, 32'h0000_0003);
		issue(CMD_GET, 32'h2222_2222, $urandom());
		issue(CMD_GET, 32'h3333_3333, $urandom());

		// capacity above the entry count behaves as the full store
		write_reg(ADDR_CAPACITY, 32'h0000_001F);
		issue(CMD_PUT, 32'h4444_4444, 32'h0000_0004);
		issue(CMD_GET, 32'h3333_3333, $urandom());
		issue(CMD_GET, 32'h4444_4444, $urandom());

		for (int p = 0; p < PHASE_COUNT; p++) run_phase(schedule[p], p == PHASE_COUNT - 1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && answers_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: lru_key_value_cache.f
design/lkv_pkg.sv
design/lkv_store.sv
design/lru_key_value_cache.sv
sim/lru_lookup_checker.sv
sim/testbench.sv
